// ===== src/mef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mef_pkg
// Shared widths, register map and reset constants of the median/EMA filter.
// ----------------------------------------------------------------------------
package mef_pkg;

    localparam int WINDOW_DEF = 8;

    localparam int DIST_W   = 16;
    localparam int STATUS_W = 8;
    localparam int ALPHA_W  = 17;
    localparam int EMA_W    = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd19661;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // word index of each register (paddr >> 2)
    localparam logic [APB_AW-3:0] REG_ALPHA = 1'b0;

endpackage

// ===== src/mef_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mef_in_if
// Poll-result channel: valid/ready handshake with the sensor poll fields.
// ----------------------------------------------------------------------------
interface mef_in_if;
    logic                          valid;
    logic                          ready;
    logic                          check_error;
    logic                          ready_req;
    logic                          read_error;
    logic [mef_pkg::STATUS_W-1:0]  range_status;
    logic [mef_pkg::DIST_W-1:0]    distance_mm;

    modport source (
        output valid, check_error, ready_req, read_error, range_status, distance_mm,
        input  ready
    );
    modport sink (
        input  valid, check_error, ready_req, read_error, range_status, distance_mm,
        output ready
    );
endinterface

// ===== src/mef_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mef_out_if
// Result channel: valid/ready handshake with the filter result fields.
// ----------------------------------------------------------------------------
interface mef_out_if;
    logic                        valid;
    logic                        ready;
    logic                        taken;
    logic                        valid_res;
    logic [mef_pkg::DIST_W-1:0]  median_mm;
    logic [mef_pkg::DIST_W-1:0]  filtered_mm;

    modport source (
        output valid, taken, valid_res, median_mm, filtered_mm,
        input  ready
    );
    modport sink (
        input  valid, taken, valid_res, median_mm, filtered_mm,
        output ready
    );
endinterface

// ===== src/median_ema_range_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_ema_range_filter
// Running median over the last WINDOW good distances, smoothed by an EMA.
//
// i_in carries one sensor poll result per transaction, o_out one result per
// poll. A poll is taken when the ready query succeeded and data was ready; it
// updates the filter when it was also read cleanly with range status zero.
// The median is found bit-serially, MSB first: one bit per cycle over all
// window entries. The EMA product alpha*(med-ema) runs as a shift-add
// multiplier, one alpha bit per cycle. A poll that does not update the filter
// goes straight to the result register; the first good poll runs the median
// search and seeds the EMA with the median; later good polls run the median
// search and then the multiplier. One poll is worked on at a time, so a new
// poll waits until the last one is stored; i_in.ready is high only between polls.
// The result register lets the next poll enter while a result waits; a
// stalled o_out holds the finished poll back before its result is stored.
// alpha is written over the APB port (byte address 0), reset value 19661;
// values above 65536 act as 65536.
// Reset empties the window and clears the EMA and the last results.
// ----------------------------------------------------------------------------
module median_ema_range_filter #(
    parameter int WINDOW = mef_pkg::WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mef_in_if.sink                       i_in,
    mef_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mef_pkg::APB_AW-1:0]   paddr,
    input  logic [mef_pkg::APB_DW-1:0]   pwdata,
    output logic [mef_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int DW  = mef_pkg::DIST_W;
    localparam int AW  = mef_pkg::ALPHA_W;
    localparam int EW  = mef_pkg::EMA_W;
    localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int DFW = EW + 1;
    localparam int ACW = EW + DW + 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_MUL,
        S_PUT
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_alpha;
    logic [DW-1:0]       r_win [WINDOW];
    logic [CW-1:0]       r_fill;
    logic [PW-1:0]       r_wpos;
    logic [EW-1:0]       r_ema;
    logic                r_started;
    logic [DW-1:0]       r_last_med;
    logic [DW-1:0]       r_last_filt;
    logic                r_taken;
    logic                r_good;
    logic [WINDOW-1:0]   r_mask;
    logic [CW-1:0]       r_rank;
    logic [4:0]          r_cnt;
    logic [DW-1:0]       r_med;
    logic [ACW-1:0]      r_acc;
    logic [ACW-1:0]      r_mcand;
    logic [AW-1:0]       r_mplier;
    logic                r_out_valid;
    logic                r_out_taken;
    logic                r_out_good;
    logic [DW-1:0]       r_out_med;
    logic [DW-1:0]       r_out_filt;

    logic                cfg_wr;
    logic                in_fire;
    logic                in_taken;
    logic                in_good;
    logic [CW-1:0]       n_fill;
    logic [WINDOW-1:0]   col;
    logic [WINDOW-1:0]   zeros;
    logic [CW-1:0]       c0;
    logic                med_bit;
    logic [DW-1:0]       n_med;
    logic [DFW-1:0]      diff;
    logic [AW-1:0]       alpha_eff;
    logic [ACW-1:0]      n_acc;
    logic [DFW-1:0]      rnd_sum;
    logic [DW-1:0]       rnd;
    logic                out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr[mef_pkg::APB_AW-1:2] == mef_pkg::REG_ALPHA);
    assign prdata  = (paddr[mef_pkg::APB_AW-1:2] == mef_pkg::REG_ALPHA)
                     ? mef_pkg::APB_DW'(r_alpha) : '0;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_taken   = !i_in.check_error && i_in.ready_req;
    assign in_good    = in_taken && !i_in.read_error && (i_in.range_status == '0);
    assign n_fill     = (r_fill == CW'(WINDOW)) ? r_fill : r_fill + CW'(1);

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            col[i] = r_win[i][r_cnt[3:0]];
        end
        zeros = r_mask & ~col;
        c0    = '0;
        for (int i = 0; i < WINDOW; i++) begin
            c0 = c0 + CW'(zeros[i]);
        end
    end

    assign med_bit   = !(r_rank < c0);
    assign n_med     = {r_med[DW-2:0], med_bit};
    assign diff      = {1'b0, n_med, {DW{1'b0}}} - {1'b0, r_ema};
    assign alpha_eff = (r_alpha > mef_pkg::ALPHA_ONE) ? mef_pkg::ALPHA_ONE : r_alpha;
    assign n_acc     = r_mplier[0] ? (r_acc + r_mcand) : r_acc;
    assign rnd_sum   = {1'b0, r_ema} + DFW'(1 << (DW - 1));
    assign rnd       = rnd_sum[EW-1:DW];
    assign out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.taken       = r_out_taken;
    assign o_out.valid_res   = r_out_good;
    assign o_out.median_mm   = r_out_med;
    assign o_out.filtered_mm = r_out_filt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= mef_pkg::ALPHA_RESET;
            r_fill      <= '0;
            r_wpos      <= '0;
            r_ema       <= '0;
            r_started   <= 1'b0;
            r_last_med  <= '0;
            r_last_filt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_alpha <= pwdata[AW-1:0];
            end
            if (r_out_valid && o_out.ready && (r_state != S_PUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_taken <= in_taken;
                        r_good  <= in_good;
                        if (in_good) begin
                            r_win[r_wpos] <= i_in.distance_mm;
                            r_wpos        <= (r_wpos == PW'(WINDOW - 1)) ? '0
                                             : r_wpos + PW'(1);
                            r_fill        <= n_fill;
                            r_rank        <= n_fill >> 1;
                            for (int i = 0; i < WINDOW; i++) begin
                                r_mask[i] <= (CW'(i) < n_fill);
                            end
                            r_cnt   <= 5'(DW - 1);
                            r_state <= S_SEL;
                        end else begin
                            r_state <= S_PUT;
                        end
                    end
                end
                S_SEL: begin
                    r_med <= n_med;
                    if (med_bit) begin
                        r_rank <= r_rank - c0;
                        r_mask <= r_mask & col;
                    end else begin
                        r_mask <= zeros;
                    end
                    if (r_cnt == '0) begin
                        if (!r_started) begin
                            r_ema     <= {n_med, {DW{1'b0}}};
                            r_started <= 1'b1;
                            r_state   <= S_PUT;
                        end else begin
                            r_acc    <= {3'b000, r_ema, {DW{1'b0}}};
                            r_mcand  <= {{(ACW-DFW){diff[DFW-1]}}, diff};
                            r_mplier <= alpha_eff;
                            r_cnt    <= 5'(AW - 1);
                            r_state  <= S_MUL;
                        end
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_MUL: begin
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == '0) begin
                        r_ema   <= n_acc[EW+DW-1:DW];
                        r_state <= S_PUT;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_taken <= r_taken;
                        r_out_good  <= r_good;
                        if (r_good) begin
                            r_out_med   <= r_med;
                            r_out_filt  <= rnd;
                            r_last_med  <= r_med;
                            r_last_filt <= rnd;
                        end else begin
                            r_out_med  <= r_last_med;
                            r_out_filt <= r_last_filt;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for median_ema_range_filter.
//
// Sensor polls are queued by the stimulus process and sent by a clocked
// driver. A shadow filter in the bench keeps its own window, fill count,
// write position and Q16.16 EMA state. For each accepted poll it predicts the
// result, and a clocked monitor compares every result transaction against the
// oldest prediction, field by field. alpha is written over APB between
// phases, while the filter is idle, and read back each time. The phases cover
// zero weight, full weight and weights above full, and use different
// sender gaps and receiver stalls. Random polls are mostly good measurements
// with random distances, mixed with failed queries, read errors and bad
// range status. A long receiver hold-off fills the filter so that it
// stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    import mef_pkg::*;

    localparam int          CLK_HALF       = 4;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned PHASE_POLLS    = 186;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int          NUM_PHASES     = 9;

    localparam logic [APB_AW-1:0] ALPHA_ADDR = {REG_ALPHA, 2'b00};

    typedef struct packed {
        logic                check_error;
        logic                ready_req;
        logic                read_error;
        logic [STATUS_W-1:0] range_status;
        logic [DIST_W-1:0]   distance_mm;
    } t_poll;

    typedef struct packed {
        logic              taken;
        logic              valid_res;
        logic [DIST_W-1:0] median_mm;
        logic [DIST_W-1:0] filtered_mm;
    } t_filter_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    mef_in_if  poll_if ();
    mef_out_if res_if ();

    median_ema_range_filter #(
        .WINDOW (WINDOW_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (poll_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow filter state
    logic [DIST_W-1:0]  shadow_window [WINDOW_DEF];
    int unsigned        shadow_fill   = 0;
    int unsigned        shadow_wpos   = 0;
    logic [EMA_W-1:0]   shadow_ema    = '0;
    logic               shadow_seeded = 1'b0;
    logic [DIST_W-1:0]  shadow_median = '0;
    logic [DIST_W-1:0]  shadow_smooth = '0;
    logic [ALPHA_W-1:0] shadow_alpha  = ALPHA_RESET;

    t_poll       poll_backlog [$];
    t_filter_out predicted_results [$];
    t_poll       cur_poll;

    int unsigned polls_queued    = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned in_idle_max     = 6;
    int unsigned out_idle_max    = 6;
    int unsigned cluster_base    = 1000;
    int unsigned send_gap        = 0;
    int unsigned recv_stall      = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap(input int unsigned hi);
        return (hi == 0) ? 0 : $urandom_range(0, hi);
    endfunction

    function automatic logic [DIST_W-1:0] window_median();
        logic [DIST_W-1:0] sorted [WINDOW_DEF];
        logic [DIST_W-1:0] v;
        int                n;
        int                j;
        n = int'(shadow_fill);
        if (n == 0) begin
            return '0;
        end
        for (int i = 0; i < n; i++) begin
            v = shadow_window[i];
            j = i;
            while (j > 0 && sorted[(j > 0) ? j - 1 : 0] > v) begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[n / 2];
    endfunction

    function automatic t_filter_out filter_predict(input t_poll p);
        t_filter_out        r;
        logic               taken;
        logic               good;
        logic [DIST_W-1:0]  med;
        logic [ALPHA_W-1:0] a;
        logic [63:0]        acc;
        logic [EMA_W:0]     rounded;
        taken = !p.check_error && p.ready_req;
        good  = taken && !p.read_error && (p.range_status == '0);
        if (good) begin
            if (shadow_fill < WINDOW_DEF) begin
                shadow_window[shadow_fill] = p.distance_mm;
                shadow_fill++;
            end else begin
                shadow_window[shadow_wpos] = p.distance_mm;
            end
            shadow_wpos = (shadow_wpos + 1) % WINDOW_DEF;
            med = window_median();
            if (!shadow_seeded) begin
                shadow_ema    = {med, 16'h0000};
                shadow_seeded = 1'b1;
            end else begin
                a   = (shadow_alpha > ALPHA_ONE) ? ALPHA_ONE : shadow_alpha;
                acc = 64'(a) * 64'({med, 16'h0000}) + 64'(ALPHA_ONE - a) * 64'(shadow_ema);
                shadow_ema = acc[47:16];
            end
            rounded       = ({1'b0, shadow_ema} + 33'h8000) >> 16;
            shadow_smooth = (rounded > 33'hFFFF) ? 16'hFFFF : rounded[DIST_W-1:0];
            shadow_median = med;
        end
        r.taken       = taken;
        r.valid_res   = good;
        r.median_mm   = shadow_median;
        r.filtered_mm = shadow_smooth;
        return r;
    endfunction

    function automatic t_poll make_poll(input logic c, input logic r, input logic e,
                                        input logic [STATUS_W-1:0] s,
                                        input logic [DIST_W-1:0] d);
        t_poll p;
        p.check_error  = c;
        p.ready_req    = r;
        p.read_error   = e;
        p.range_status = s;
        p.distance_mm  = d;
        return p;
    endfunction

    function automatic t_poll random_poll();
        t_poll       p;
        int unsigned kind;
        int unsigned dsel;
        kind = $urandom_range(0, 99);
        dsel = $urandom_range(0, 99);
        if (dsel < 50) begin
            p.distance_mm = DIST_W'($urandom);
        end else if (dsel < 85) begin
            p.distance_mm = DIST_W'(cluster_base + $urandom_range(0, 200));
        end else begin
            case ($urandom_range(0, 3))
                0:       p.distance_mm = 16'h0000;
                1:       p.distance_mm = 16'hFFFF;
                2:       p.distance_mm = DIST_W'($urandom_range(0, 3));
                default: p.distance_mm = DIST_W'(32'hFFFF - $urandom_range(0, 3));
            endcase
        end
        if (kind < 75) begin
            p.check_error  = 1'b0;
            p.ready_req    = 1'b1;
            p.read_error   = 1'b0;
            p.range_status = '0;
        end else if (kind < 85) begin
            p.check_error  = 1'b0;
            p.ready_req    = 1'b1;
            p.read_error   = 1'($urandom_range(0, 1));
            p.range_status = STATUS_W'($urandom_range(1, 255));
        end else begin
            p.check_error  = 1'($urandom_range(0, 1));
            p.ready_req    = 1'($urandom_range(0, 1));
            p.read_error   = 1'($urandom_range(0, 1));
            p.range_status = STATUS_W'($urandom);
        end
        return p;
    endfunction

    task automatic queue_poll(input t_poll p);
        poll_backlog.push_back(p);
        polls_queued++;
    endtask

    task automatic wait_drained();
        while (results_checked != polls_queued) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ALPHA_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_alpha(input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] rb;
        apb_access(1'b1, value, rb);
        apb_access(1'b0, '0, rb);
        shadow_alpha = value[ALPHA_W-1:0];
        if (rb[ALPHA_W-1:0] !== shadow_alpha) begin
            $error("alpha readback: expected %0d, actual %0d", shadow_alpha, rb[ALPHA_W-1:0]);
            mismatch_count++;
        end
    endtask

    // poll driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poll_if.valid <= 1'b0;
            send_gap = 0;
        end else if (!poll_if.valid || poll_if.ready) begin
            if (poll_if.valid) begin
                predicted_results.push_back(filter_predict(cur_poll));
            end
            if (send_gap != 0) begin
                send_gap--;
                poll_if.valid <= 1'b0;
            end else if (poll_backlog.size() != 0) begin
                cur_poll = poll_backlog.pop_front();
                poll_if.check_error  <= cur_poll.check_error;
                poll_if.ready_req    <= cur_poll.ready_req;
                poll_if.read_error   <= cur_poll.read_error;
                poll_if.range_status <= cur_poll.range_status;
                poll_if.distance_mm  <= cur_poll.distance_mm;
                poll_if.valid        <= 1'b1;
                send_gap = pick_gap(in_idle_max);
            end else begin
                poll_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_filter_out got;
        t_filter_out want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.taken       = res_if.taken;
                got.valid_res   = res_if.valid_res;
                got.median_mm   = res_if.median_mm;
                got.filtered_mm = res_if.filtered_mm;
                if (predicted_results.size() == 0) begin
                    $error("result transaction with no poll outstanding");
                    mismatch_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (got.taken !== want.taken) begin
                        $error("taken: expected %0d, actual %0d", want.taken, got.taken);
                        mismatch_count++;
                    end
                    if (got.valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0d, actual %0d",
                               want.valid_res, got.valid_res);
                        mismatch_count++;
                    end
                    if (got.median_mm !== want.median_mm) begin
                        $error("median_mm: expected %0d, actual %0d",
                               want.median_mm, got.median_mm);
                        mismatch_count++;
                    end
                    if (got.filtered_mm !== want.filtered_mm) begin
                        $error("filtered_mm: expected %0d, actual %0d",
                               want.filtered_mm, got.filtered_mm);
                        mismatch_count++;
                    end
                end
                results_checked++;
                recv_stall = (results_checked % 600 == 100) ? HOLD_CYCLES
                                                            : pick_gap(out_idle_max);
            end else if (recv_stall != 0) begin
                recv_stall--;
            end
            res_if.ready <= (recv_stall == 0);
        end
    end

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((poll_if.valid && poll_if.ready) || (res_if.valid && res_if.ready)
                    || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [APB_DW-1:0] alpha_plan [NUM_PHASES];
        logic [APB_DW-1:0] rb;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        poll_if.valid        = 1'b0;
        poll_if.check_error  = 1'b0;
        poll_if.ready_req    = 1'b0;
        poll_if.read_error   = 1'b0;
        poll_if.range_status = '0;
        poll_if.distance_mm  = '0;
        res_if.ready         = 1'b0;
        cur_poll             = '0;
        for (int i = 0; i < WINDOW_DEF; i++) shadow_window[i] = '0;

        alpha_plan[0] = 32'd0;
        alpha_plan[1] = 32'd65536;
        alpha_plan[2] = 32'hFFFF_FFFF;
        alpha_plan[3] = 32'd1;
        alpha_plan[4] = 32'd32768;
        alpha_plan[5] = 32'd65537;
        alpha_plan[6] = $urandom_range(0, 131071);
        alpha_plan[7] = 32'd65535;
        alpha_plan[8] = 32'(ALPHA_RESET);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_access(1'b0, '0, rb);
        if (rb[ALPHA_W-1:0] !== ALPHA_RESET) begin
            $error("alpha after reset: expected %0d, actual %0d", ALPHA_RESET, rb[ALPHA_W-1:0]);
            mismatch_count++;
        end

        // directed: flag combinations, extremes, seeding, fill and wrap of the window
        queue_poll(make_poll(1'b1, 1'b1, 1'b0, 8'h00, 16'd1234));
        queue_poll(make_poll(1'b0, 1'b0, 1'b0, 8'h00, 16'd1234));
        queue_poll(make_poll(1'b0, 1'b1, 1'b1, 8'h00, 16'd1234));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'hFF, 16'd1234));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h01, 16'd1234));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'hFFFF));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'h0000));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'h0000));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'h8000));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'h7FFF));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'h0001));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'hFFFE));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'd100));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'd200));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'h5555));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'hAAAA));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'h0000));
        queue_poll(make_poll(1'b0, 1'b1, 1'b0, 8'h00, 16'hFFFF));
        queue_poll(make_poll(1'b1, 1'b1, 1'b1, 8'hFF, 16'hFFFF));
        queue_poll(make_poll(1'b0, 1'b1, 1'b1, 8'hAA, 16'h0000));
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_alpha(alpha_plan[ph]);
            case (ph % 3)
                0: begin
                    in_idle_max  = 0;
                    out_idle_max = 0;
                end
                1: begin
                    in_idle_max  = 6;
                    out_idle_max = 6;
                end
                default: begin
                    in_idle_max  = (ph % 2) ? 6 : 0;
                    out_idle_max = (ph % 2) ? 0 : 6;
                end
            endcase
            cluster_base = $urandom_range(0, 65535 - 200);
            for (int k = 0; k < PHASE_POLLS; k++) queue_poll(random_poll());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
